// ----- src/lhp_pkg.sv -----
// ----------------------------------------------------------------------------
// lhp_pkg
// Shared widths, command codes and control structs for the latency histogram
// profiler.
// ----------------------------------------------------------------------------
package lhp_pkg;

	// Payload field widths
	localparam int CMD_W     = 2;
	localparam int SLOT_IN_W = 3;
	localparam int NOW_W     = 32;
	localparam int RBIN_W    = 8;
	localparam int COUNT_W   = 32;
	localparam int BIN_OUT_W = 8;

	// Default parameter values
	localparam int TOP_BIN_DEF = 255;
	localparam int SLOTS_DEF   = 8;

	typedef enum logic [CMD_W-1:0] {
		CMD_START = 2'd0,
		CMD_STOP  = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_READ  = 2'd3
	} cmd_t;

	// Controller to datapath
	typedef struct packed {
		logic accept;  // latch item, issue histogram read
		logic finish;  // update state, load result register
		logic sweep;   // write one zero entry of the clearing pass
	} ctrl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic out_busy;    // result register full and not taken
		logic sweep_last;  // clearing pass at its last entry
		logic is_clear;    // item at work is a clear command
	} ctrl_sts_t;

endpackage

// ----- src/lhp_req_if.sv -----
// ----------------------------------------------------------------------------
// lhp_req_if
// Request channel: one command item per handshake.
// ----------------------------------------------------------------------------
interface lhp_req_if import lhp_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CMD_W-1:0]     command;
	logic [SLOT_IN_W-1:0] slot;
	logic [NOW_W-1:0]     now;
	logic [RBIN_W-1:0]    read_bin;

	modport source (output valid, command, slot, now, read_bin, input ready);
	modport sink   (input valid, command, slot, now, read_bin, output ready);
endinterface

// ----- src/lhp_rsp_if.sv -----
// ----------------------------------------------------------------------------
// lhp_rsp_if
// Response channel: one result item per handshake.
// ----------------------------------------------------------------------------
interface lhp_rsp_if import lhp_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [COUNT_W-1:0]   count;
	logic [BIN_OUT_W-1:0] bin;
	logic                 recorded;

	modport source (output valid, count, bin, recorded, input ready);
	modport sink   (input valid, count, bin, recorded, output ready);
endinterface

// ----- src/lhp_cfg_if.sv -----
// ----------------------------------------------------------------------------
// lhp_cfg_if
// Configuration write channel for the enable register.
// ----------------------------------------------------------------------------
interface lhp_cfg_if ();
	logic valid;
	logic ready;
	logic data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

// ----- src/lhp_ctrl.sv -----
// ----------------------------------------------------------------------------
// lhp_ctrl
// Sequencer: clearing pass, item accept, finish with result handoff.
// ----------------------------------------------------------------------------
module lhp_ctrl import lhp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  ctrl_sts_t sts,
	output logic      in_ready,
	output ctrl_cmd_t cmd
);

	typedef enum logic [1:0] {
		S_SWEEP,
		S_IDLE,
		S_FIN
	} state_t;

	state_t state_q;
	logic   in_ready_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_SWEEP;
			in_ready_q <= 1'b0;
		end else begin
			case (state_q)
				S_SWEEP: begin
					if (sts.sweep_last) begin
						state_q    <= S_IDLE;
						in_ready_q <= 1'b1;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						state_q    <= S_FIN;
						in_ready_q <= 1'b0;
					end
				end
				S_FIN: begin
					if (!sts.out_busy) begin
						if (sts.is_clear) begin
							state_q <= S_SWEEP;
						end else begin
							state_q    <= S_IDLE;
							in_ready_q <= 1'b1;
						end
					end
				end
				default: begin
					state_q    <= S_SWEEP;
					in_ready_q <= 1'b0;
				end
			endcase
		end
	end

	assign in_ready   = in_ready_q;
	assign cmd.accept = in_valid && in_ready_q;
	assign cmd.finish = (state_q == S_FIN) && !sts.out_busy;
	assign cmd.sweep  = (state_q == S_SWEEP);

endmodule

// ----- src/lhp_datapath.sv -----
// ----------------------------------------------------------------------------
// lhp_datapath
// Start-time registers, histogram memory, elapsed-time binning and result
// register.
// ----------------------------------------------------------------------------
module lhp_datapath import lhp_pkg::*; #(
	parameter int TOP_BIN = TOP_BIN_DEF,
	parameter int SLOTS   = SLOTS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ctrl_cmd_t            cmd,
	output ctrl_sts_t            sts,
	input  logic                 cfg_we,
	input  logic                 cfg_data,
	input  logic [CMD_W-1:0]     in_command,
	input  logic [SLOT_IN_W-1:0] in_slot,
	input  logic [NOW_W-1:0]     in_now,
	input  logic [RBIN_W-1:0]    in_read_bin,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [COUNT_W-1:0]   out_count,
	output logic [BIN_OUT_W-1:0] out_bin,
	output logic                 out_recorded
);

	// Only slots the slot field can address hold storage
	localparam int SLOT_SPAN  = 2 ** SLOT_IN_W;
	localparam int NSLOT      = (SLOTS < SLOT_SPAN) ? SLOTS : SLOT_SPAN;
	localparam int SLOT_W     = (NSLOT > 1) ? $clog2(NSLOT) : 1;
	localparam int NSLOT_ROWS = 2 ** SLOT_W;
	localparam int BIN_W      = $clog2(TOP_BIN + 1);
	localparam int ADDR_W     = SLOT_W + BIN_W;
	localparam int DEPTH      = 2 ** ADDR_W;
	localparam int SLOT_CMP_W = SLOT_IN_W + 1;
	localparam int RB_CMP_W   = ((BIN_W > RBIN_W) ? BIN_W : RBIN_W) + 1;

	logic                enable_q;
	logic [NOW_W-1:0]    start_q [NSLOT_ROWS];
	logic [COUNT_W-1:0]  mem [DEPTH];
	logic [COUNT_W-1:0]  rd_q;
	logic [ADDR_W-1:0]   sweep_cnt_q;

	// Item at work
	cmd_t                cmd_q;
	logic [SLOT_W-1:0]   sidx_q;
	logic                slot_ok_q;
	logic                rbin_ok_q;
	logic [NOW_W-1:0]    now_q;
	logic [RBIN_W-1:0]   rbin_q;
	logic [BIN_W-1:0]    bidx_q;

	// Result register
	logic                out_valid_q;
	logic [COUNT_W-1:0]  count_q;
	logic [BIN_OUT_W-1:0] bin_q;
	logic                rec_q;

	logic [SLOT_W-1:0]   sidx;
	logic                slot_ok;
	logic                rbin_ok;
	logic [NOW_W-1:0]    dt;
	logic [BIN_W-1:0]    dt_bin;
	logic [BIN_W-1:0]    bidx;
	logic                stop_act;
	logic                start_act;
	logic [COUNT_W-1:0]  inc;
	logic                mem_we;
	logic [ADDR_W-1:0]   mem_waddr;
	logic [COUNT_W-1:0]  mem_wdata;

	// Binning at accept: elapsed ticks clamped to the top bin
	always_comb begin
		sidx    = in_slot[SLOT_W-1:0];
		slot_ok = {1'b0, in_slot} < SLOT_CMP_W'(NSLOT);
		rbin_ok = RB_CMP_W'(in_read_bin) <= RB_CMP_W'(TOP_BIN);
		dt      = in_now - start_q[sidx];
		dt_bin  = (dt > NOW_W'(TOP_BIN)) ? BIN_W'(TOP_BIN) : dt[BIN_W-1:0];
		bidx    = (cmd_t'(in_command) == CMD_STOP) ? dt_bin : BIN_W'(in_read_bin);
	end

	assign stop_act  = (cmd_q == CMD_STOP) && enable_q && slot_ok_q;
	assign start_act = (cmd_q == CMD_START) && enable_q && slot_ok_q;
	assign inc       = rd_q + COUNT_W'(1);

	assign mem_we    = cmd.sweep || (cmd.finish && stop_act);
	assign mem_waddr = cmd.sweep ? sweep_cnt_q : {sidx_q, bidx_q};
	assign mem_wdata = cmd.sweep ? '0 : inc;

	// Histogram memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (cmd.accept) begin
			rd_q <= mem[{sidx, bidx}];
		end
	end

	// Latch the accepted item
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cmd_q     <= cmd_t'(in_command);
			sidx_q    <= sidx;
			slot_ok_q <= slot_ok;
			rbin_ok_q <= rbin_ok;
			now_q     <= in_now;
			rbin_q    <= in_read_bin;
			bidx_q    <= bidx;
		end
	end

	// Enable register, start times, clearing pass counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q    <= 1'b0;
			sweep_cnt_q <= '0;
			for (int i = 0; i < NSLOT_ROWS; i++) begin
				start_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				enable_q <= cfg_data;
			end
			if (cmd.sweep) begin
				sweep_cnt_q <= sweep_cnt_q + ADDR_W'(1);
			end
			if (cmd.finish && (cmd_q == CMD_CLEAR)) begin
				for (int i = 0; i < NSLOT_ROWS; i++) begin
					start_q[i] <= '0;
				end
			end else if (cmd.finish && start_act) begin
				start_q[sidx_q] <= now_q;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			count_q <= '0;
			bin_q   <= '0;
			rec_q   <= stop_act;
			if (stop_act) begin
				count_q <= inc;
				bin_q   <= BIN_OUT_W'(bidx_q);
			end else if (cmd_q == CMD_READ) begin
				bin_q <= rbin_q;
				if (slot_ok_q && rbin_ok_q) begin
					count_q <= rd_q;
				end
			end
		end
	end

	assign sts.out_busy   = out_valid_q && !out_ready;
	assign sts.sweep_last = (sweep_cnt_q == ADDR_W'(DEPTH - 1));
	assign sts.is_clear   = (cmd_q == CMD_CLEAR);

	assign out_valid    = out_valid_q;
	assign out_count    = count_q;
	assign out_bin      = bin_q;
	assign out_recorded = rec_q;

endmodule

// ----- src/latency_histogram_profiler.sv -----
// ----------------------------------------------------------------------------
// latency_histogram_profiler
// Per-slot start timestamps and elapsed-time histograms driven by command
// items.
// ----------------------------------------------------------------------------
// Usage:
//   req  - command items: start, stop, clear, read. Accepted on valid & ready.
//   rsp  - one result item per request: count, bin, recorded.
//   cfg  - writes the enable bit; always ready. Write only while idle.
// Operation:
//   Start, stop and read: the accept step looks up the slot's start time,
//   bins the elapsed ticks and reads the histogram memory; the finish step,
//   once the result register is free, does the increment and write back and
//   loads the result register. A new item is taken only after that finish.
//   Clear adds a clearing pass over the whole histogram memory, 2048 entries
//   with defaults, one memory entry per cycle; its result is offered as the
//   pass starts.
// Reset:
//   Enable and start times go to zero, then the same clearing pass runs over
//   the histogram memory; req.ready stays low until it is done.
// Stall:
//   A result waits in the output register; one further item may be accepted
//   meanwhile and then holds until the output register frees up.
// ----------------------------------------------------------------------------
module latency_histogram_profiler import lhp_pkg::*; #(
	parameter int TOP_BIN = TOP_BIN_DEF,
	parameter int SLOTS   = SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	lhp_req_if.sink     req,
	lhp_rsp_if.source   rsp,
	lhp_cfg_if.sink     cfg
);

	ctrl_cmd_t ctrl_cmd;
	ctrl_sts_t ctrl_sts;

	// Enable register takes a write in any cycle
	assign cfg.ready = 1'b1;

	lhp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.sts      (ctrl_sts),
		.in_ready (req.ready),
		.cmd      (ctrl_cmd)
	);

	lhp_datapath #(
		.TOP_BIN (TOP_BIN),
		.SLOTS   (SLOTS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (ctrl_cmd),
		.sts          (ctrl_sts),
		.cfg_we       (cfg.valid && cfg.ready),
		.cfg_data     (cfg.data),
		.in_command   (req.command),
		.in_slot      (req.slot),
		.in_now       (req.now),
		.in_read_bin  (req.read_bin),
		.out_valid    (rsp.valid),
		.out_ready    (rsp.ready),
		.out_count    (rsp.count),
		.out_bin      (rsp.bin),
		.out_recorded (rsp.recorded)
	);

endmodule

// ----- src/lhp_checker.sv -----
// ----------------------------------------------------------------------------
// lhp_checker
// Port-level checks of the profiler's handshakes and item accounting.
// ----------------------------------------------------------------------------
module lhp_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready
);

	logic [1:0] pending_q;
	logic       req_acc;
	logic       rsp_acc;

	assign req_acc = req_valid && req_ready;
	assign rsp_acc = rsp_valid && rsp_ready;

	// Items accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (req_acc && !rsp_acc) begin
			pending_q <= pending_q + 2'd1;
		end else if (rsp_acc && !req_acc) begin
			pending_q <= pending_q - 2'd1;
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> !req_ready)
		else $error("request accepted back to back");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pending_q != 2'd0)
		else $error("response without an accepted request");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 2'd2)
		else $error("more than two items outstanding");

endmodule

bind latency_histogram_profiler lhp_checker u_lhp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready)
);

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the latency histogram profiler. A queue of command
// items feeds a clocked driver. A clocked monitor checks every result item
// against a behavioral predictor. The predictor keeps its own start stamps,
// bin counts and enable bit. Both channels idle at random, and one phase
// holds the result side off long enough to back the block up.
// ----------------------------------------------------------------------------
module testbench;
	import lhp_pkg::*;

	localparam int TOP_BIN         = TOP_BIN_DEF;
	localparam int SLOTS           = SLOTS_DEF;
	// Clear and reset both sweep the whole histogram memory, one entry a cycle
	localparam int CLEAR_SWEEP     = 2048;
	localparam int SETTLE_CYCLES   = CLEAR_SWEEP + 64;
	localparam int TAIL_CYCLES     = 20;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int WATCHDOG_LIMIT  = 20000;
	localparam int MAX_REPORTS     = 10;
	localparam int NUM_PHASES      = 5;

	typedef struct {
		cmd_t                 command;
		logic [SLOT_IN_W-1:0] slot;
		logic [NOW_W-1:0]     now;
		logic [RBIN_W-1:0]    read_bin;
	} prof_item_t;

	typedef struct {
		logic [COUNT_W-1:0]   count;
		logic [BIN_OUT_W-1:0] bin;
		logic                 recorded;
	} prof_result_t;

	logic clk;
	logic arst_n;

	lhp_req_if req_ch ();
	lhp_rsp_if rsp_ch ();
	lhp_cfg_if cfg_ch ();

	latency_histogram_profiler #(
		.TOP_BIN (TOP_BIN),
		.SLOTS   (SLOTS)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// Predictor state: mirrors what the block should hold
	logic [NOW_W-1:0]   start_stamp [SLOTS];
	logic [COUNT_W-1:0] bin_counts  [SLOTS][TOP_BIN+1];
	logic               enable_bit;

	prof_item_t   pending_items    [$];
	prof_result_t expected_results [$];

	bit          req_fired    = 1'b0;
	logic        offer_next;
	logic        take_next;
	int unsigned send_gap     = 0;
	int unsigned rsp_gap      = 0;
	bit          calm         = 1'b0;
	bit          hold_go      = 1'b0;
	int unsigned hold_left    = 0;
	int unsigned quiet_cycles = 0;
	int unsigned cycle_count  = 0;
	int unsigned mismatches   = 0;
	int unsigned phase_tally  = 0;

	// Free-running clock, 2 ns period
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Zero every slot's start stamp and bin counts, as clear and reset do
	function automatic void wipe_profiles();
		for (int s = 0; s < SLOTS; s++) begin
			start_stamp[s] = '0;
			for (int b = 0; b <= TOP_BIN; b++)
				bin_counts[s][b] = '0;
		end
	endfunction

	// Apply one command item to the predictor and return the result it causes
	function automatic prof_result_t profile_step(prof_item_t it);
		prof_result_t     res;
		logic [NOW_W-1:0] elapsed;
		res.count    = '0;
		res.bin      = '0;
		res.recorded = 1'b0;
		case (it.command)
			CMD_START: begin
				// Ignore starts while disabled or on a slot that does not exist
				if (enable_bit && it.slot < SLOTS)
					start_stamp[it.slot] = it.now;
			end
			CMD_STOP: begin
				if (enable_bit && it.slot < SLOTS) begin
					// Elapsed ticks wrap modulo 2^32, then clamp into the top bin
					elapsed = it.now - start_stamp[it.slot];
					if (elapsed > TOP_BIN)
						elapsed = TOP_BIN;
					bin_counts[it.slot][elapsed] = bin_counts[it.slot][elapsed] + 1'b1;
					res.count    = bin_counts[it.slot][elapsed];
					res.bin      = elapsed[BIN_OUT_W-1:0];
					res.recorded = 1'b1;
				end
			end
			CMD_CLEAR: begin
				// Clear acts whatever enable holds
				wipe_profiles();
			end
			default: begin
				// Read echoes the bin; out-of-range slot or bin reads as zero
				res.bin = it.read_bin;
				if (it.slot < SLOTS && it.read_bin <= TOP_BIN)
					res.count = bin_counts[it.slot][it.read_bin];
			end
		endcase
		return res;
	endfunction

	// Idle length for either side: mostly none or short, a few long
	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Queue one item and count it toward the phase length
	function automatic void queue_item(cmd_t c, logic [SLOT_IN_W-1:0] s,
			logic [NOW_W-1:0] t, logic [RBIN_W-1:0] rb);
		prof_item_t it;
		it.command  = c;
		it.slot     = s;
		it.now      = t;
		it.read_bin = rb;
		pending_items.push_back(it);
		phase_tally++;
	endfunction

	// Tick offset from a start: mostly small so bins pile up, some past the top
	function automatic logic [NOW_W-1:0] pick_delta();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return $urandom_range(0, 40);
		if (r < 95)
			return $urandom_range(0, 300);
		return $urandom;
	endfunction

	function automatic void report_mismatch(string msg);
		if (mismatches < MAX_REPORTS)
			$display("%s", msg);
		mismatches++;
	endfunction

	// Write the enable register; the block must be idle
	task automatic write_enable(logic value);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= value;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		enable_bit = value;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// Wait until every item is sent and answered, then let the block settle
	task automatic drain_profiler(int unsigned settle);
		while (pending_items.size() != 0 || expected_results.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	// Random traffic: mostly start/stop runs on one slot, plus reads and noise
	task automatic run_random_phase(int unsigned target);
		int unsigned          r;
		int unsigned          pick;
		logic [SLOT_IN_W-1:0] s;
		logic [NOW_W-1:0]     t0;
		logic [NOW_W-1:0]     d;
		cmd_t                 c;
		@(posedge clk);
		phase_tally = 0;
		while (phase_tally < target) begin
			r = $urandom_range(0, 99);
			if (r < 55) begin
				// Well-formed run: one start, a few stops, reads of the bins hit
				s  = SLOT_IN_W'($urandom_range(0, 7));
				t0 = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 300)
					: $urandom;
				queue_item(CMD_START, s, t0, RBIN_W'($urandom));
				repeat ($urandom_range(1, 4)) begin
					d = pick_delta();
					queue_item(CMD_STOP, s, t0 + d, RBIN_W'($urandom));
					if ($urandom_range(0, 1))
						queue_item(CMD_READ, s, $urandom,
							(d > TOP_BIN) ? RBIN_W'(TOP_BIN) : RBIN_W'(d));
				end
			end else if (r < 85) begin
				queue_item(CMD_READ, SLOT_IN_W'($urandom), $urandom,
					RBIN_W'($urandom_range(0, 1) ? $urandom_range(0, 40) : $urandom));
			end else if (r < 98) begin
				pick = $urandom_range(0, 2);
				c = (pick == 0) ? CMD_START : (pick == 1) ? CMD_STOP : CMD_READ;
				queue_item(c, SLOT_IN_W'($urandom), $urandom, RBIN_W'($urandom));
			end else begin
				queue_item(CMD_CLEAR, SLOT_IN_W'($urandom), $urandom, RBIN_W'($urandom));
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Request driver: hold an offered item until taken, then idle a while
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && req_ch.valid && req_ch.ready && pending_items.size() != 0) begin
			expected_results.push_back(profile_step(pending_items.pop_front()));
			req_fired = 1'b1;
		end
	end

	always @(negedge clk) begin
		offer_next = req_ch.valid;
		// Drop the item just taken and draw the gap before the next one
		if (req_fired) begin
			req_fired  = 1'b0;
			offer_next = 1'b0;
			send_gap   = idle_len();
		end
		if (!offer_next) begin
			if (send_gap != 0) begin
				send_gap--;
			end else if (pending_items.size() != 0) begin
				offer_next        = 1'b1;
				req_ch.command  <= pending_items[0].command;
				req_ch.slot     <= pending_items[0].slot;
				req_ch.now      <= pending_items[0].now;
				req_ch.read_bin <= pending_items[0].read_bin;
			end
		end
		req_ch.valid <= offer_next;
	end

	// ------------------------------------------------------------------------
	// Result monitor: compare each taken result with the oldest expectation
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		prof_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf(
					"unexpected result: count=%0d bin=%0d recorded=%0b",
					rsp_ch.count, rsp_ch.bin, rsp_ch.recorded));
			end else begin
				want = expected_results.pop_front();
				if (rsp_ch.count !== want.count || rsp_ch.bin !== want.bin
						|| rsp_ch.recorded !== want.recorded)
					report_mismatch($sformatf({
						"result mismatch: expected count=%0d bin=%0d recorded=%0b,",
						" got count=%0d bin=%0d recorded=%0b"},
						want.count, want.bin, want.recorded,
						rsp_ch.count, rsp_ch.bin, rsp_ch.recorded));
			end
		end
	end

	// Receiver readiness: random stalls, overridden by the long hold-off
	always @(negedge clk) begin
		if (hold_left != 0) begin
			take_next = 1'b0;
		end else if (rsp_gap != 0) begin
			rsp_gap--;
			take_next = 1'b0;
		end else begin
			rsp_gap   = idle_len();
			take_next = (rsp_gap == 0);
			if (rsp_gap != 0)
				rsp_gap--;
		end
		rsp_ch.ready <= take_next;
	end

	// Long hold-off on the result side, counted in cycles
	always @(posedge clk) begin
		if (hold_go) begin
			hold_go = 1'b0;
			hold_left <= HOLD_OFF_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Watchdog on handshakes; also switch idling off for stretches
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count % 150 == 0)
			calm = ($urandom_range(0, 3) == 0);
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Sequence: reset, directed items, then random phases across enable values
	// ------------------------------------------------------------------------
	initial begin
		int unsigned phase_len [NUM_PHASES];
		phase_len = '{400, 120, 300, 80, 200};

		// Drive every input to a known value from time zero
		arst_n          = 1'b0;
		req_ch.valid    = 1'b0;
		req_ch.command  = CMD_START;
		req_ch.slot     = '0;
		req_ch.now      = '0;
		req_ch.read_bin = '0;
		rsp_ch.ready    = 1'b0;
		cfg_ch.valid    = 1'b0;
		cfg_ch.data     = 1'b0;
		wipe_profiles();
		enable_bit = 1'b0;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		// Let the reset sweep over the histogram memory finish
		repeat (SETTLE_CYCLES) @(posedge clk);

		// Disabled: start and stop do nothing, read and clear still act
		write_enable(1'b0);
		@(posedge clk);
		queue_item(CMD_START, 3'd0, 32'h0000_0000, 8'd0);
		queue_item(CMD_STOP,  3'd7, 32'hFFFF_FFFF, 8'd255);
		queue_item(CMD_READ,  3'd0, 32'h0000_0000, 8'd0);
		queue_item(CMD_READ,  3'd7, 32'hFFFF_FFFF, 8'd255);
		queue_item(CMD_CLEAR, 3'd5, 32'hA5A5_5A5A, 8'hAA);
		drain_profiler(SETTLE_CYCLES);

		// Enabled: wrap of the tick counter, zero elapsed, exact top, clamping
		write_enable(1'b1);
		@(posedge clk);
		queue_item(CMD_START, 3'd0, 32'hFFFF_FFFF, 8'd0);
		queue_item(CMD_STOP,  3'd0, 32'h0000_0004, 8'd0);
		queue_item(CMD_STOP,  3'd0, 32'h0000_0004, 8'd255);
		queue_item(CMD_START, 3'd7, 32'h8000_0000, 8'd0);
		queue_item(CMD_STOP,  3'd7, 32'h8000_0000, 8'd0);
		queue_item(CMD_STOP,  3'd7, 32'h8000_00FF, 8'd0);
		queue_item(CMD_STOP,  3'd7, 32'h7FFF_FFFF, 8'd0);
		queue_item(CMD_START, 3'd3, 32'h1234_5678, 8'd0);
		queue_item(CMD_STOP,  3'd3, 32'h1234_5778, 8'd0);
		queue_item(CMD_READ,  3'd0, 32'h0000_0000, 8'd5);
		queue_item(CMD_READ,  3'd7, 32'h0000_0000, 8'd255);
		queue_item(CMD_READ,  3'd7, 32'hFFFF_FFFF, 8'd0);
		queue_item(CMD_READ,  3'd3, 32'h0000_0000, 8'd255);
		queue_item(CMD_CLEAR, 3'd0, 32'h0000_0000, 8'd0);
		queue_item(CMD_READ,  3'd0, 32'h0000_0000, 8'd5);
		queue_item(CMD_STOP,  3'd0, 32'h0000_0005, 8'd0);
		queue_item(CMD_READ,  3'd0, 32'h0000_0000, 8'd5);
		drain_profiler(SETTLE_CYCLES);

		// Random phases alternate enable; the middle one backs the block up
		for (int p = 0; p < NUM_PHASES; p++) begin
			write_enable(p % 2 == 0);
			if (p == 2) begin
				@(negedge clk);
				hold_go = 1'b1;
			end
			run_random_phase(phase_len[p]);
			drain_profiler((p == NUM_PHASES - 1) ? TAIL_CYCLES : SETTLE_CYCLES);
		end

		if (mismatches == 0 && expected_results.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ----- sim.f -----
src/lhp_pkg.sv
src/lhp_req_if.sv
src/lhp_rsp_if.sv
src/lhp_cfg_if.sv
src/lhp_ctrl.sv
src/lhp_datapath.sv
src/latency_histogram_profiler.sv
src/lhp_checker.sv
dv/testbench.sv
